/* rtl/packet_window_rate_meter_unit_assert.svh */
// Assertion macros for the rate meter block.
// PWRM_ASSERT_IMPL: overlapping implication, PWRM_ASSERT_NEXT: next-cycle implication.
`ifndef PACKET_WINDOW_RATE_METER_UNIT_ASSERT_SVH
`define PACKET_WINDOW_RATE_METER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define PWRM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PWRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PWRM_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define PWRM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/pwrm_pkg.sv */
`default_nettype none

package pwrm_pkg;

  localparam int STAMP_W     = 52;
  localparam int ALU_W       = STAMP_W + 1;
  localparam int SECS_W      = 32;
  localparam int MICROS_W    = 20;
  localparam int LEN_W       = 16;
  localparam int BYTES_W     = 32;
  localparam int AVG_W       = 32;
  localparam int OUT_CNT_W   = 16;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 80;
  localparam int DIV_STEPS   = STAMP_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [MICROS_W-1:0] US_PER_SECOND = 20'd1000000;
  localparam logic [31:0]         WINDOW_RESET  = 32'd1000000;

  typedef logic [STAMP_W-1:0] stamp_t;

  // clamp a 52-bit time to 32 bits
  function automatic logic [AVG_W-1:0] sat_u32(input stamp_t v);
    logic [AVG_W-1:0] r;
    if (|v[STAMP_W-1:AVG_W]) begin
      r = '1;
    end else begin
      r = v[AVG_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/packet_window_rate_meter_unit.sv */
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_tvalid/tready   | in_tdata: packet header
// out_     | output    | out_tvalid/tready  | out_tdata: window stats, out_tuser: closed
// cfg_     | input     | cfg_wr_en          | cfg_wr_data: window length (us)
//
// One request in flight; in_tready is high only while the sequencer idles.
// Open window: accept, multiply, 5 steps on the shared adder, out.
// A close skips the byte accumulate; with three or more packets a 52-step
// restoring divide runs on the same adder after the compare.
// A finished result waits in the output register; the next request is taken meanwhile.
// rst_n is synchronous; it clears the window state and sets window_us to 1000000.
`default_nettype none

`include "packet_window_rate_meter_unit_assert.svh"

module packet_window_rate_meter_unit
  import pwrm_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [31:0] stamp_seconds, [51:32] stamp_micros, [67:52] captured_length,
  // [83:68] wire_length
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [15:0] packet_count, [47:16] byte_total, [79:48] avg_gap_us
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [0] window_closed
  output logic [0:0]                 out_tuser,
  input  wire logic                  cfg_wr_en,
  input  wire logic [31:0]           cfg_wr_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_STAMP = 4'd2;
  localparam logic [3:0] S_GAP   = 4'd3;
  localparam logic [3:0] S_ELAP  = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // control and window state
  logic [3:0]             state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            window_us_r, window_us_nxt;
  logic                   seen_first_r, seen_first_nxt;
  stamp_t                 last_stamp_r, last_stamp_nxt;
  stamp_t                 elapsed_r, elapsed_nxt;
  logic [COUNT_WIDTH-1:0] packets_r, packets_nxt;
  logic [BYTES_W-1:0]     bytes_r, bytes_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;

  // payload
  logic [SECS_W-1:0]      secs_r, secs_nxt;
  logic [MICROS_W-1:0]    micros_r, micros_nxt;
  logic [LEN_W-1:0]       caplen_r, caplen_nxt;
  logic [LEN_W-1:0]       wirelen_r, wirelen_nxt;
  stamp_t                 prod_r, prod_nxt;
  stamp_t                 stamp_r, stamp_nxt;
  stamp_t                 gap_r, gap_nxt;
  stamp_t                 elap_new_r, elap_new_nxt;
  logic [ALU_W-1:0]       rem_r, rem_nxt;
  stamp_t                 quo_r, quo_nxt;
  logic [COUNT_WIDTH-1:0] div_r, div_nxt;
  logic                   res_closed_r, res_closed_nxt;
  logic [OUT_CNT_W-1:0]   res_count_r, res_count_nxt;
  logic [BYTES_W-1:0]     res_bytes_r, res_bytes_nxt;
  logic [AVG_W-1:0]       res_avg_r, res_avg_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;

  // shared add/subtract unit
  logic [ALU_W-1:0]       alu_a;
  logic [ALU_W-1:0]       alu_b;
  logic                   alu_sub;
  logic [ALU_W:0]         alu_sum;
  logic                   alu_carry;

  logic [ALU_W-1:0]       div_shift;
  logic [31:0]            packets_ext;
  logic [OUT_CNT_W-1:0]   count_sat;
  logic                   in_fire;
  logic                   out_free;

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{ALU_W{1'b0}}, alu_sub};
  // on subtract, carry out means a >= b
  assign alu_carry = alu_sum[ALU_W];

  assign div_shift   = {rem_r[ALU_W-2:0], quo_r[STAMP_W-1]};
  assign packets_ext = 32'(packets_r);
  assign count_sat   = (|packets_ext[31:OUT_CNT_W]) ? '1 : packets_ext[OUT_CNT_W-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_STAMP: begin
        alu_a = ALU_W'(prod_r);
        alu_b = ALU_W'(micros_r);
      end
      S_GAP: begin
        alu_a   = ALU_W'(stamp_r);
        alu_b   = ALU_W'(last_stamp_r);
        alu_sub = 1'b1;
      end
      S_ELAP: begin
        alu_a = ALU_W'(elapsed_r);
        alu_b = ALU_W'(gap_r);
      end
      S_CMP: begin
        alu_a   = ALU_W'(window_us_r);
        alu_b   = ALU_W'(elap_new_r);
        alu_sub = 1'b1;
      end
      S_ACC: begin
        alu_a = ALU_W'(bytes_r);
        alu_b = ALU_W'(caplen_r);
      end
      S_DIV: begin
        alu_a   = div_shift;
        alu_b   = ALU_W'(div_r);
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    window_us_nxt  = window_us_r;
    seen_first_nxt = seen_first_r;
    last_stamp_nxt = last_stamp_r;
    elapsed_nxt    = elapsed_r;
    packets_nxt    = packets_r;
    bytes_nxt      = bytes_r;
    div_cnt_nxt    = div_cnt_r;
    secs_nxt       = secs_r;
    micros_nxt     = micros_r;
    caplen_nxt     = caplen_r;
    wirelen_nxt    = wirelen_r;
    prod_nxt       = prod_r;
    stamp_nxt      = stamp_r;
    gap_nxt        = gap_r;
    elap_new_nxt   = elap_new_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_nxt        = div_r;
    res_closed_nxt = res_closed_r;
    res_count_nxt  = res_count_r;
    res_bytes_nxt  = res_bytes_r;
    res_avg_nxt    = res_avg_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;

    if (cfg_wr_en) begin
      window_us_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          secs_nxt    = in_tdata[31:0];
          micros_nxt  = in_tdata[51:32];
          caplen_nxt  = in_tdata[67:52];
          wirelen_nxt = in_tdata[83:68];
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = STAMP_W'(secs_r) * STAMP_W'(US_PER_SECOND);
        state_nxt = S_STAMP;
      end
      S_STAMP: begin
        stamp_nxt = alu_sum[STAMP_W-1:0];
        state_nxt = S_GAP;
      end
      S_GAP: begin
        // backwards time and the first packet give a zero gap
        gap_nxt        = (seen_first_r && alu_carry) ? alu_sum[STAMP_W-1:0] : '0;
        last_stamp_nxt = stamp_r;
        seen_first_nxt = 1'b1;
        state_nxt      = S_ELAP;
      end
      S_ELAP: begin
        elap_new_nxt = alu_sum[STAMP_W] ? '1 : alu_sum[STAMP_W-1:0];
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        if (alu_carry) begin
          elapsed_nxt = elap_new_r;
          if (packets_r != '1) begin
            packets_nxt = packets_r + COUNT_WIDTH'(1);
          end
          state_nxt = S_ACC;
        end else begin
          res_closed_nxt = 1'b1;
          res_count_nxt  = count_sat;
          res_bytes_nxt  = bytes_r;
          if (packets_r >= COUNT_WIDTH'(3)) begin
            quo_nxt     = elapsed_r;
            rem_nxt     = '0;
            div_nxt     = packets_r - COUNT_WIDTH'(1);
            div_cnt_nxt = DIV_CNT_W'(DIV_STEPS);
            state_nxt   = S_DIV;
          end else begin
            res_avg_nxt = (packets_r == COUNT_WIDTH'(2)) ? sat_u32(elapsed_r) : '0;
            state_nxt   = S_OUT;
          end
          elapsed_nxt = gap_r;
          packets_nxt = COUNT_WIDTH'(1);
          bytes_nxt   = BYTES_W'(wirelen_r);
        end
      end
      S_ACC: begin
        bytes_nxt      = alu_sum[BYTES_W] ? '1 : alu_sum[BYTES_W-1:0];
        res_closed_nxt = 1'b0;
        res_count_nxt  = '0;
        res_bytes_nxt  = '0;
        res_avg_nxt    = '0;
        state_nxt      = S_OUT;
      end
      S_DIV: begin
        rem_nxt     = alu_carry ? alu_sum[ALU_W-1:0] : div_shift;
        quo_nxt     = {quo_r[STAMP_W-2:0], alu_carry};
        div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(1)) begin
          res_avg_nxt = sat_u32(quo_nxt);
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_closed_r;
          out_data_nxt  = {res_avg_r, res_bytes_r, res_count_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      window_us_r  <= WINDOW_RESET;
      seen_first_r <= 1'b0;
      last_stamp_r <= '0;
      elapsed_r    <= '0;
      packets_r    <= '0;
      bytes_r      <= '0;
      div_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      window_us_r  <= window_us_nxt;
      seen_first_r <= seen_first_nxt;
      last_stamp_r <= last_stamp_nxt;
      elapsed_r    <= elapsed_nxt;
      packets_r    <= packets_nxt;
      bytes_r      <= bytes_nxt;
      div_cnt_r    <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    secs_r       <= secs_nxt;
    micros_r     <= micros_nxt;
    caplen_r     <= caplen_nxt;
    wirelen_r    <= wirelen_nxt;
    prod_r       <= prod_nxt;
    stamp_r      <= stamp_nxt;
    gap_r        <= gap_nxt;
    elap_new_r   <= elap_new_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    div_r        <= div_nxt;
    res_closed_r <= res_closed_nxt;
    res_count_r  <= res_count_nxt;
    res_bytes_r  <= res_bytes_nxt;
    res_avg_r    <= res_avg_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  `PWRM_ASSERT_NEXT(a_accept_starts_mul, clk, rst_n, in_tvalid && in_tready, state_r == S_MUL)
  `PWRM_ASSERT_IMPL(a_open_result_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0)
  `PWRM_ASSERT_IMPL(a_div_cnt_idle, clk, rst_n, state_r != S_DIV, div_cnt_r == '0)
  `PWRM_ASSERT_IMPL(a_window_nonempty, clk, rst_n, state_r == S_IDLE && seen_first_r,
                    packets_r != '0)

endmodule

`default_nettype wire

/* tb/packet_window_rate_meter_unit_tb.sv */
module packet_window_rate_meter_unit_tb
  import pwrm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int BURST_HEADERS = 14;
  localparam logic [63:0] STAMP_MASK = (64'd1 << STAMP_W) - 64'd1;
  localparam logic [63:0] STAMP_TOP = 64'd4294967295999999;

  typedef struct packed {
    logic [SECS_W-1:0]   secs;
    logic [MICROS_W-1:0] micros;
    logic [LEN_W-1:0]    cap_len;
    logic [LEN_W-1:0]    wire_len;
  } hdr_t;

  typedef struct packed {
    logic                 closed;
    logic [OUT_CNT_W-1:0] pkt_count;
    logic [BYTES_W-1:0]   byte_sum;
    logic [AVG_W-1:0]     avg_gap;
  } stats_t;

  typedef struct packed {
    hdr_t   hdr;
    logic   typed;
    stats_t want;
  } dir_row_t;

  // typed rows carry the report worked out by hand, the rest use the predictor
  localparam dir_row_t DIR_ROWS [16] = '{
    '{'{32'd0, 20'd0, 16'd100, 16'd200}, 1'b1, '{1'b0, 16'd0, 32'd0, 32'd0}},
    '{'{32'd0, 20'd500000, 16'd65535, 16'd0}, 1'b1, '{1'b0, 16'd0, 32'd0, 32'd0}},
    '{'{32'd0, 20'd999999, 16'd0, 16'd0}, 1'b1, '{1'b0, 16'd0, 32'd0, 32'd0}},
    '{'{32'd1, 20'd0, 16'd65535, 16'd0}, 1'b1, '{1'b0, 16'd0, 32'd0, 32'd0}},
    '{'{32'd1, 20'd1, 16'd9, 16'd65535}, 1'b1, '{1'b1, 16'd4, 32'd131170, 32'd333333}},
    '{'{32'd0, 20'd0, 16'd7, 16'd3}, 1'b1, '{1'b0, 16'd0, 32'd0, 32'd0}},
    '{'{32'hFFFFFFFF, 20'd999999, 16'd0, 16'd12345}, 1'b1,
      '{1'b1, 16'd2, 32'd65542, 32'd1}},
    '{'{32'hFFFFFFFF, 20'hFFFFF, 16'd0, 16'd0}, 1'b1, '{1'b1, 16'd1, 32'd12345, 32'd0}},
    '{'{32'hFFFFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{1'b0, 16'd0, 32'd0, 32'd0}},
    '{'{32'd0, 20'd0, 16'd1, 16'd1}, 1'b0, '0},
    '{'{32'd0, 20'd1000000, 16'd2, 16'd2}, 1'b0, '0},
    '{'{32'd2, 20'd0, 16'h8000, 16'h8000}, 1'b0, '0},
    '{'{32'd2, 20'd0, 16'h5555, 16'hAAAA}, 1'b0, '0},
    '{'{32'd3, 20'd999999, 16'hAAAA, 16'h5555}, 1'b0, '0},
    '{'{32'hAAAAAAAA, 20'h55555, 16'h1234, 16'h4321}, 1'b0, '0},
    '{'{32'h55555555, 20'hAAAAA, 16'd0, 16'd0}, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [31:0]           cfg_wr_data = '0;

  // meter state as the block should hold it
  logic [31:0]      m_window = WINDOW_RESET;
  logic             m_seen = 1'b0;
  stamp_t           m_last = '0;
  stamp_t           m_elapsed = '0;
  logic [CNT_W-1:0] m_pkts = '0;
  logic [31:0]      m_bytes = '0;

  stats_t expected_reports [$];
  int     errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_closed = 0;
  int     n_windows = 0;
  int     quiet = 0;
  int     stall_left = 0;
  logic   stall_on = 1'b0;

  packet_window_rate_meter_unit #(
    .COUNT_WIDTH(CNT_W)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic advance_meter(input hdr_t h, output stats_t r);
    logic [63:0] stamp;
    logic [63:0] gap;
    logic [63:0] prior_elapsed;
    logic [63:0] acc;
    logic [63:0] avg;
    stamp = (64'(h.secs) * 64'd1000000 + 64'(h.micros)) & STAMP_MASK;
    gap = 64'd0;
    if (m_seen && stamp > 64'(m_last)) begin
      gap = stamp - 64'(m_last);
    end
    m_seen = 1'b1;
    m_last = stamp[STAMP_W-1:0];
    prior_elapsed = 64'(m_elapsed);
    acc = prior_elapsed + gap;
    m_elapsed = (acc > STAMP_MASK) ? STAMP_MASK[STAMP_W-1:0] : acc[STAMP_W-1:0];
    r = '0;
    if (64'(m_elapsed) <= 64'(m_window)) begin
      if (m_pkts != '1) begin
        m_pkts = m_pkts + 1'b1;
      end
      acc = 64'(m_bytes) + 64'(h.cap_len);
      m_bytes = (acc > 64'hFFFFFFFF) ? 32'hFFFFFFFF : acc[31:0];
    end else begin
      avg = 64'd0;
      if (m_pkts >= 3) begin
        avg = prior_elapsed / (64'(m_pkts) - 64'd1);
      end else if (m_pkts == 2) begin
        avg = prior_elapsed;
      end
      r.closed = 1'b1;
      r.pkt_count = (64'(m_pkts) > 64'hFFFF) ? 16'hFFFF : OUT_CNT_W'(m_pkts);
      r.byte_sum = m_bytes;
      r.avg_gap = (avg > 64'hFFFFFFFF) ? 32'hFFFFFFFF : avg[31:0];
      m_elapsed = gap[STAMP_W-1:0];
      m_pkts = CNT_W'(1);
      m_bytes = 32'(h.wire_len);
    end
  endtask

  task automatic send_header(input hdr_t h, input logic use_typed, input stats_t typed_want);
    stats_t pred;
    stats_t exp_rep;
    in_tdata <= {4'b0, h.wire_len, h.cap_len, h.micros, h.secs};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_meter(h, pred);
    exp_rep = use_typed ? typed_want : pred;
    expected_reports = {expected_reports, exp_rep};
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_window(input logic [31:0] w);
    drain_reports();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    m_window = w;
    n_windows++;
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return LEN_W'($urandom);
  endfunction

  // mostly well-formed traffic sized to the window, plus backward stamps,
  // big jumps and fully random headers
  task automatic run_phase(input logic [31:0] w, input int n_items, input logic idle_on,
                           input logic stall_mode, input logic mid_pause);
    hdr_t        h;
    logic [63:0] cur;
    logic [63:0] secs_v;
    logic [63:0] us_v;
    logic [63:0] back;
    logic [63:0] span;
    int          kind;
    int          idle;
    write_window(w);
    stall_on = stall_mode;
    for (int i = 0; i < n_items; i++) begin
      if (mid_pause && i == n_items / 2) begin
        drain_reports();
      end
      cur = 64'(m_last);
      kind = $urandom_range(0, 99);
      h.cap_len = pick_len();
      h.wire_len = pick_len();
      if (kind >= 94) begin
        h.secs = $urandom;
        h.micros = MICROS_W'($urandom_range(0, (1 << MICROS_W) - 1));
      end else begin
        if (kind < 70) begin
          span = 64'(w) / 64'($urandom_range(1, 8));
          cur += 64'($urandom_range(0, span[31:0]));
        end else if (kind < 80) begin
          // land on the window edge or one past it
          if (64'(w) >= 64'(m_elapsed)) begin
            cur += 64'(w) - 64'(m_elapsed);
          end
          cur += 64'($urandom_range(0, 1));
        end else if (kind < 88) begin
          back = 64'($urandom);
          if (back > cur) back = cur;
          cur -= back;
        end else begin
          cur += 64'($urandom) * 64'($urandom_range(1, 1000));
        end
        if (cur > STAMP_TOP) cur = STAMP_TOP;
        secs_v = cur / 64'd1000000;
        us_v = cur % 64'd1000000;
        // same instant written with micros past one second
        if (secs_v != 0 && us_v <= 64'd48575 && $urandom_range(0, 7) == 0) begin
          secs_v -= 64'd1;
          us_v += 64'd1000000;
        end
        h.secs = secs_v[SECS_W-1:0];
        h.micros = us_v[MICROS_W-1:0];
      end
      idle = 0;
      if (idle_on) begin
        kind = $urandom_range(0, 15);
        if (kind >= 15) idle = $urandom_range(10, 60);
        else if (kind >= 10) idle = $urandom_range(1, 3);
      end
      if (idle > 0) begin
        in_tvalid <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      send_header(h, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (!stall_on) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : report_mon
    stats_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t ns: report with no request pending, actual tuser %0d tdata %h",
                   $time, out_tuser, out_tdata);
        end
      end else begin
        want = expected_reports.pop_front();
        check_field("window_closed", 32'(want.closed), 32'(out_tuser[0]));
        check_field("packet_count", 32'(want.pkt_count), 32'(out_tdata[15:0]));
        check_field("byte_total", want.byte_sum, out_tdata[47:16]);
        check_field("avg_gap_us", want.avg_gap, out_tdata[79:48]);
        n_checked++;
        if (want.closed) n_closed++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    hdr_t burst_hdr;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows run at the reset window
    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      send_header(DIR_ROWS[i].hdr, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    run_phase(32'd1, 190, 1'b1, 1'b1, 1'b0);
    run_phase(32'hFFFFFFFF, 190, 1'b1, 1'b0, 1'b0);
    run_phase(32'd0, 190, 1'b0, 1'b0, 1'b0);
    run_phase(32'd250, 190, 1'b1, 1'b1, 1'b1);
    run_phase($urandom_range(1000, 200000), 190, 1'b1, 1'b1, 1'b0);
    run_phase(WINDOW_RESET, 190, 1'b1, 1'b1, 1'b1);
    run_phase($urandom, 190, 1'b0, 1'b1, 1'b0);
    run_phase(32'd5000, 190, 1'b1, 1'b0, 1'b0);

    // a burst at a single instant keeps a tiny window open on zero gaps
    write_window(32'd10);
    stall_on = 1'b0;
    burst_hdr = '{32'd4000, 20'd0, 16'hFFFF, 16'd0};
    for (int i = 0; i < BURST_HEADERS; i++) begin
      burst_hdr.wire_len = LEN_W'($urandom);
      send_header(burst_hdr, 1'b0, '0);
    end
    burst_hdr.micros = 20'd11;
    send_header(burst_hdr, 1'b0, '0);

    drain_reports();
    repeat (80) @(posedge clk);
    $display("%0d packet headers sent, %0d reports checked, %0d of them closed windows",
             n_sent, n_checked, n_closed);
    $display("%0d window settings written incl. 0, 1 and max; backward stamps and bursts seen",
             n_windows);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
